// ----- sv/rbi_pkg.sv -----
// shared types, constants and the bin function of the bin index builder
package rbi_pkg;

	// default values for the top level parameters
	localparam int WINDOW_SHIFT_DEF = 14;
	localparam int COORD_BITS_DEF   = 29;
	localparam int SEQ_ID_BITS_DEF  = 16;

	// fixed field widths
	localparam int SEQ_W  = 16;
	localparam int POS_W  = 30;
	localparam int OFF_W  = 64;
	localparam int KIND_W = 2;
	localparam int BIN_W  = 16;
	localparam int WIN_W  = 15;
	localparam int BIN_CW = 29;

	// depth of the command queue between front and back, a power of two
	localparam int QUEUE_DEPTH = 2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CHUNK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RUN    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UNSORT = 2'd2;
	localparam logic [KIND_W-1:0] KIND_OFFSET = 2'd3;

	// sticky error state, shares codes with the error kinds
	localparam logic [KIND_W-1:0] ERR_NONE = 2'd0;

	// input operations
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// first bin number of each level
	localparam logic [BIN_W-1:0] BIN_BASE_16K  = 16'd4681;
	localparam logic [BIN_W-1:0] BIN_BASE_128K = 16'd585;
	localparam logic [BIN_W-1:0] BIN_BASE_1M   = 16'd73;
	localparam logic [BIN_W-1:0] BIN_BASE_8M   = 16'd9;
	localparam logic [BIN_W-1:0] BIN_BASE_64M  = 16'd1;

	// work handed from front to back: an error, or a run and/or a chunk
	typedef struct packed {
		logic [KIND_W-1:0] err;
		logic              run;
		logic              chk;
		logic [SEQ_W-1:0]  run_seq;
		logic [WIN_W-1:0]  win_first;
		logic [WIN_W-1:0]  win_last;
		logic [OFF_W-1:0]  off;
		logic [SEQ_W-1:0]  chk_seq;
		logic [BIN_W-1:0]  chk_bin;
		logic [OFF_W-1:0]  chk_begin;
	} rbi_cmd_t;

	// one result item
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  chunk_seq;
		logic [BIN_W-1:0]  bin_number;
		logic [OFF_W-1:0]  chunk_begin;
		logic [OFF_W-1:0]  chunk_finish;
		logic [WIN_W-1:0]  window_first;
		logic [WIN_W-1:0]  window_last;
		logic [OFF_W-1:0]  window_offset;
		logic              last;
	} rbi_res_t;

	// smallest bin that holds the inclusive range b..e
	function automatic logic [BIN_W-1:0] bin_of(input logic [BIN_CW-1:0] b,
			input logic [BIN_CW-1:0] e);
		logic [BIN_W-1:0] bin;
		bin = '0;
		if ((b >> 14) == (e >> 14)) begin
			bin = BIN_BASE_16K + BIN_W'(b >> 14);
		end else if ((b >> 17) == (e >> 17)) begin
			bin = BIN_BASE_128K + BIN_W'(b >> 17);
		end else if ((b >> 20) == (e >> 20)) begin
			bin = BIN_BASE_1M + BIN_W'(b >> 20);
		end else if ((b >> 23) == (e >> 23)) begin
			bin = BIN_BASE_8M + BIN_W'(b >> 23);
		end else if ((b >> 26) == (e >> 26)) begin
			bin = BIN_BASE_64M + BIN_W'(b >> 26);
		end
		return bin;
	endfunction

endpackage

// ----- sv/rbi_if.sv -----
// record and result channel interfaces

// record channel
interface rbi_rec_if import rbi_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             op;
	logic [SEQ_W-1:0] seq_id;
	logic [POS_W-1:0] start_pos;
	logic [POS_W-1:0] stop_pos;
	logic [OFF_W-1:0] file_offset;

	modport source (output valid, op, seq_id, start_pos, stop_pos, file_offset,
		input ready);
	modport sink (input valid, op, seq_id, start_pos, stop_pos, file_offset,
		output ready);
endinterface

// result channel
interface rbi_res_if import rbi_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [SEQ_W-1:0]  chunk_seq;
	logic [BIN_W-1:0]  bin_number;
	logic [OFF_W-1:0]  chunk_begin;
	logic [OFF_W-1:0]  chunk_finish;
	logic [WIN_W-1:0]  window_first;
	logic [WIN_W-1:0]  window_last;
	logic [OFF_W-1:0]  window_offset;
	logic              last;

	modport source (output valid, kind, chunk_seq, bin_number, chunk_begin,
		chunk_finish, window_first, window_last, window_offset, last,
		input ready);
	modport sink (input valid, kind, chunk_seq, bin_number, chunk_begin,
		chunk_finish, window_first, window_last, window_offset, last,
		output ready);
endinterface

// ----- sv/rbi_front.sv -----
// front end: classifies records, tracks index state, issues commands
module rbi_front import rbi_pkg::*; #(
	parameter int WINDOW_SHIFT = WINDOW_SHIFT_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int SEQ_ID_BITS  = SEQ_ID_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rbi_rec_if.sink   rec,
	output logic      push,
	output rbi_cmd_t  push_data,
	input  logic      full
);

	localparam int WW  = (COORD_BITS > WINDOW_SHIFT) ? COORD_BITS - WINDOW_SHIFT : 1;
	localparam int NWW = WW + 1;
	localparam int SW  = (SEQ_ID_BITS < SEQ_W) ? SEQ_ID_BITS : SEQ_W;
	localparam logic [POS_W-1:0] CoordMax = POS_W'((64'd1 << COORD_BITS) - 64'd1);

	// classify stage signals
	logic [POS_W-1:0]      startm1, stopm1, begc, endc;
	logic [COORD_BITS-1:0] beg, endm1;
	logic [WW-1:0]         wbeg, wend;

	// stage 1 registers
	logic             s1_vld_q;
	logic             op_s1;
	logic [SW-1:0]    seq_s1;
	logic [POS_W-1:0] start_s1;
	logic [OFF_W-1:0] off_s1;
	logic [BIN_W-1:0] bin_s1;
	logic [NWW-1:0]   wbeg1_s1;
	logic [WW-1:0]    wend_s1;
	logic [NWW-1:0]   wend1_s1;
	logic             span_s1;

	// index state
	logic              prev_seq_vld_q, open_vld_q, seen_q;
	logic [KIND_W-1:0] err_q;
	logic [NWW-1:0]    nw_q;
	logic [SW-1:0]     prev_seq_q, open_seq_q;
	logic [BIN_W-1:0]  prev_bin_q, open_bin_q;
	logic [OFF_W-1:0]  prev_off_q, open_off_q;
	logic [POS_W-1:0]  prev_start_q;

	// state stage signals
	logic              fire, seq_hit, unsorted, off_bad, run, chk, chk_new;
	logic [KIND_W-1:0] err_nx;
	logic [NWW-1:0]    nw_eff, first, nw_nx;

	// clamp coordinates and find bin and windows
	always_comb begin
		startm1 = (rec.start_pos == '0) ? '0 : rec.start_pos - 1'b1;
		stopm1  = (rec.stop_pos == '0) ? '0 : rec.stop_pos - 1'b1;
		begc    = (startm1 > CoordMax) ? CoordMax : startm1;
		endc    = (stopm1 > CoordMax) ? CoordMax : stopm1;
		if (endc < begc) begin
			endc = begc;
		end
		beg   = begc[COORD_BITS-1:0];
		endm1 = endc[COORD_BITS-1:0];
		wbeg  = WW'(beg >> WINDOW_SHIFT);
		wend  = WW'(endm1 >> WINDOW_SHIFT);
	end

	assign rec.ready = !s1_vld_q || !full;
	assign fire      = s1_vld_q && !full;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (rec.ready) begin
			s1_vld_q <= rec.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (rec.ready && rec.valid) begin
			op_s1    <= rec.op;
			seq_s1   <= SW'(rec.seq_id);
			start_s1 <= rec.start_pos;
			off_s1   <= rec.file_offset;
			bin_s1   <= bin_of(BIN_CW'(beg), BIN_CW'(endm1));
			wbeg1_s1 <= NWW'(wbeg) + 1'b1;
			wend_s1  <= wend;
			wend1_s1 <= NWW'(wend) + 1'b1;
			span_s1  <= (wbeg != wend);
		end
	end

	// error checks and run and chunk decisions
	always_comb begin
		seq_hit  = prev_seq_vld_q && (seq_s1 == prev_seq_q);
		unsorted = (op_s1 == OP_RECORD) && seq_hit && (start_s1 < prev_start_q);
		off_bad  = seen_q && (off_s1 <= prev_off_q);
		case (err_q)
			ERR_NONE: begin
				err_nx = unsorted ? KIND_UNSORT : (off_bad ? KIND_OFFSET : ERR_NONE);
			end
			KIND_OFFSET: begin
				err_nx = unsorted ? KIND_UNSORT : KIND_OFFSET;
			end
			default: begin
				err_nx = err_q;
			end
		endcase

		nw_eff  = seq_hit ? nw_q : '0;
		first   = (wbeg1_s1 > nw_eff) ? wbeg1_s1 : nw_eff;
		nw_nx   = (span_s1 && (wend1_s1 > nw_eff)) ? wend1_s1 : nw_eff;
		chk_new = !seq_hit || (bin_s1 != prev_bin_q);
		if (op_s1 == OP_FINISH) begin
			run = 1'b0;
			chk = open_vld_q;
		end else begin
			run = span_s1 && (first <= NWW'(wend_s1));
			chk = chk_new && open_vld_q;
		end
		if (err_nx != ERR_NONE) begin
			run = 1'b0;
			chk = 1'b0;
		end
	end

	// command to the back end
	always_comb begin
		push                = fire && ((err_nx != ERR_NONE) || run || chk);
		push_data.err       = err_nx;
		push_data.run       = run;
		push_data.chk       = chk;
		push_data.run_seq   = SEQ_W'(seq_s1);
		push_data.win_first = WIN_W'(first);
		push_data.win_last  = WIN_W'(wend_s1);
		push_data.off       = off_s1;
		push_data.chk_seq   = SEQ_W'(open_seq_q);
		push_data.chk_bin   = open_bin_q;
		push_data.chk_begin = open_off_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_seq_vld_q <= 1'b0;
			open_vld_q     <= 1'b0;
			seen_q         <= 1'b0;
			err_q          <= ERR_NONE;
			nw_q           <= '0;
		end else if (fire) begin
			if (err_nx != ERR_NONE) begin
				err_q <= err_nx;
			end else if (op_s1 == OP_FINISH) begin
				prev_seq_vld_q <= 1'b0;
				open_vld_q     <= 1'b0;
				seen_q         <= 1'b0;
				nw_q           <= '0;
			end else begin
				prev_seq_vld_q <= 1'b1;
				seen_q         <= 1'b1;
				nw_q           <= nw_nx;
				if (chk_new) begin
					open_vld_q <= 1'b1;
				end
			end
		end
	end

	// record state payload
	always_ff @(posedge clk) begin
		if (fire && (err_nx == ERR_NONE) && (op_s1 == OP_RECORD)) begin
			prev_seq_q   <= seq_s1;
			prev_off_q   <= off_s1;
			prev_start_q <= start_s1;
			prev_bin_q   <= bin_s1;
			if (chk_new) begin
				open_seq_q <= seq_s1;
				open_bin_q <= bin_s1;
				open_off_q <= off_s1;
			end
		end
	end

endmodule

// ----- sv/rbi_queue.sv -----
// short command queue between front and back
module rbi_queue import rbi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  rbi_cmd_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     pop_vld,
	output rbi_cmd_t pop_data
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	rbi_cmd_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;

	assign full     = (cnt_q == CNTW'(QUEUE_DEPTH));
	assign pop_vld  = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && pop_vld) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !(pop && pop_vld)) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(push && !full) && (pop && pop_vld)) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- sv/rbi_back.sv -----
// back end: expands commands into result items behind an output register
module rbi_back import rbi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_vld,
	input  rbi_cmd_t  q_data,
	output logic      pop,
	rbi_res_if.source res
);

	logic     out_vld_q, pend_vld_q;
	rbi_res_t res_q, pend_q;
	logic     slot_free;
	rbi_res_t head_res, chunk_res;

	assign slot_free = !out_vld_q || res.ready;
	assign pop       = slot_free && !pend_vld_q && q_vld;

	// results that the head command gives
	always_comb begin
		chunk_res              = '0;
		chunk_res.kind         = KIND_CHUNK;
		chunk_res.chunk_seq    = q_data.chk_seq;
		chunk_res.bin_number   = q_data.chk_bin;
		chunk_res.chunk_begin  = q_data.chk_begin;
		chunk_res.chunk_finish = q_data.off;
		chunk_res.last         = 1'b1;

		head_res = '0;
		if (q_data.err != ERR_NONE) begin
			head_res.kind = q_data.err;
			head_res.last = 1'b1;
		end else if (q_data.run) begin
			head_res.kind          = KIND_RUN;
			head_res.chunk_seq     = q_data.run_seq;
			head_res.window_first  = q_data.win_first;
			head_res.window_last   = q_data.win_last;
			head_res.window_offset = q_data.off;
			head_res.last          = !q_data.chk;
		end else begin
			head_res = chunk_res;
		end
	end

	// output and pending valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else if (slot_free) begin
			out_vld_q <= pend_vld_q || q_vld;
			if (pend_vld_q) begin
				pend_vld_q <= 1'b0;
			end else if (q_vld) begin
				pend_vld_q <= (q_data.err == ERR_NONE) && q_data.run && q_data.chk;
			end
		end
	end

	// output and pending payload
	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (pend_vld_q) begin
				res_q <= pend_q;
			end else if (q_vld) begin
				res_q  <= head_res;
				pend_q <= chunk_res;
			end
		end
	end

	assign res.valid         = out_vld_q;
	assign res.kind          = res_q.kind;
	assign res.chunk_seq     = res_q.chunk_seq;
	assign res.bin_number    = res_q.bin_number;
	assign res.chunk_begin   = res_q.chunk_begin;
	assign res.chunk_finish  = res_q.chunk_finish;
	assign res.window_first  = res_q.window_first;
	assign res.window_last   = res_q.window_last;
	assign res.window_offset = res_q.window_offset;
	assign res.last          = res_q.last;

endmodule

// ----- sv/record_bin_index_builder.sv -----
// top level of the streaming bin and linear index builder
//
// rec carries sorted interval records (op record) and a closing finish item
// with the end offset; res carries bin chunks, linear window runs and
// sticky error items, with last set on the final result of each item.
// Both channels use valid/ready; an item moves when both are high.
// The front end registers the clamped coordinates, bin and windows, then
// updates the index state from those registers and pushes a command into a
// two-entry queue. The back end turns each command into one or two results
// in an output register.
// A result passes through the stage 1 registers, the queue and the output
// register. An item giving a run and a chunk holds the back end while its
// second result goes out, as there is a single result port.
// When res stalls, the queue and the stage before it fill and rec.ready
// drops; nothing is lost. Reset clears the index state flags and the
// sticky error and empties the pipeline; no clearing pass is needed.
module record_bin_index_builder import rbi_pkg::*; #(
	parameter int WINDOW_SHIFT = WINDOW_SHIFT_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int SEQ_ID_BITS  = SEQ_ID_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rbi_rec_if.sink   rec,
	rbi_res_if.source res
);

	logic     push, full, pop, q_vld;
	rbi_cmd_t push_data, q_data;

	// record classification and index state
	rbi_front #(
		.WINDOW_SHIFT(WINDOW_SHIFT),
		.COORD_BITS  (COORD_BITS),
		.SEQ_ID_BITS (SEQ_ID_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec      (rec),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	// command queue
	rbi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_vld  (q_vld),
		.pop_data (q_data)
	);

	// result emission
	rbi_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.q_vld (q_vld),
		.q_data(q_data),
		.pop   (pop),
		.res   (res)
	);

endmodule
